[rtl/register_bytecode_executor_macros.svh]
// Assertion macros for the register bytecode executor.
// Expects clk_i and rst_ni in the scope of use.
`ifndef REGISTER_BYTECODE_EXECUTOR_MACROS_SVH
`define REGISTER_BYTECODE_EXECUTOR_MACROS_SVH

// Property checked on every clock, off while reset is asserted.
`define RBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Trigger in one cycle implies the property in the next.
`define RBE_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

[rtl/rbe_pkg.sv]
// Shared types and constants of the register bytecode executor.
// No dependencies.
`default_nettype none

package rbe_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned CntW  = $clog2(DataW);

  typedef enum logic [2:0] {
    OpLoadk = 3'd0,
    OpAdd   = 3'd1,
    OpSub   = 3'd2,
    OpMul   = 3'd3,
    OpDiv   = 3'd4,
    OpPrint = 3'd5,
    OpHalt  = 3'd6,
    OpNop   = 3'd7
  } op_e;

  localparam logic KindValue   = 1'b0;
  localparam logic KindDivZero = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

[rtl/rbe_regfile.sv]
// Register file: one write port, two registered read ports, per-entry valid bits.
// Depends on rbe_pkg.
`default_nettype none

module rbe_regfile #(
  parameter int unsigned REGISTER_COUNT = 256
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      re_i,
  input  wire logic [rbe_pkg::IdxW-1:0]  ra_addr_i,
  input  wire logic [rbe_pkg::IdxW-1:0]  rb_addr_i,
  output logic      [rbe_pkg::DataW-1:0] ra_data_o,
  output logic      [rbe_pkg::DataW-1:0] rb_data_o,
  input  wire logic                      we_i,
  input  wire logic [rbe_pkg::IdxW-1:0]  wa_i,
  input  wire logic [rbe_pkg::DataW-1:0] wd_i
);
  import rbe_pkg::*;

  localparam int unsigned AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [IdxW:0] Count = (IdxW + 1)'(REGISTER_COUNT);

  logic [DataW-1:0]          mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_q;
  logic [DataW-1:0]          ra_q, rb_q;
  logic                      ra_hit_q, rb_hit_q;
  logic                      ra_in, rb_in, w_in;

  assign ra_in = {1'b0, ra_addr_i} < Count;
  assign rb_in = {1'b0, rb_addr_i} < Count;
  assign w_in  = {1'b0, wa_i} < Count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i && w_in) begin
      valid_q[wa_i[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && w_in) begin
      mem[wa_i[AW-1:0]] <= wd_i;
    end
    if (re_i) begin
      ra_q     <= mem[ra_addr_i[AW-1:0]];
      rb_q     <= mem[rb_addr_i[AW-1:0]];
      ra_hit_q <= ra_in && valid_q[ra_addr_i[AW-1:0]];
      rb_hit_q <= rb_in && valid_q[rb_addr_i[AW-1:0]];
    end
  end

  assign ra_data_o = ra_hit_q ? ra_q : '0;
  assign rb_data_o = rb_hit_q ? rb_q : '0;

endmodule

`default_nettype wire

[rtl/rbe_divider.sv]
// Signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on rbe_pkg. Divisor must be nonzero.
`default_nettype none

module rbe_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rbe_pkg::DataW-1:0] dividend_i,
  input  wire logic [rbe_pkg::DataW-1:0] divisor_i,
  output rbe_pkg::div_status_t           status_o,
  output logic      [rbe_pkg::DataW-1:0] quotient_o
);
  import rbe_pkg::*;

  logic             busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW:0]   rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d, dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DataW:0]   shifted, trial;

  assign shifted = {rem_q[DataW-1:0], quo_q[DataW-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
      dvs_d  = divisor_i[DataW-1] ? (DataW'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (trial[DataW]) begin
        rem_d = shifted;
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

[rtl/register_bytecode_executor.sv]
// Register bytecode executor: sequencer, ALU and output register.
// Depends on rbe_pkg, rbe_regfile, rbe_divider and the assertion macros header.
//
// Use:
//   The input channel takes one decoded instruction per word (in_valid_i,
//   in_stall_o and the instruction fields). The output channel gives at most
//   one word per instruction (out_valid_o, out_stall_i, kind_o, value_o):
//   a printed register value, or a divide-by-zero error with value zero.
//   Sequence: an instruction is accepted with its register read, then
//   executed; a divide with nonzero divisor then waits for the divider,
//   which produces one quotient bit per cycle, and writes the quotient back.
//   in_stall_o is high while an instruction is in flight, so no new word is taken.
//   A result waits in the output register; while the receiver stalls and the
//   register is full, a print or divide error holds in execute until it
//   frees. Other instructions proceed regardless.
//   After halt, words are accepted and dropped, one per cycle, until one
//   carries end_of_program_i, which clears the halt.
//   Reset clears all registers to zero at once, leaves the block running and
//   the output channel empty; words are accepted the cycle after reset.
`default_nettype none
`include "register_bytecode_executor_macros.svh"

module register_bytecode_executor #(
  parameter int unsigned REGISTER_COUNT = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [2:0]                       operation_i,
  input  wire logic [rbe_pkg::IdxW-1:0]         dest_index_i,
  input  wire logic [rbe_pkg::IdxW-1:0]         left_index_i,
  input  wire logic [rbe_pkg::IdxW-1:0]         right_index_i,
  input  wire logic signed [rbe_pkg::DataW-1:0] constant_i,
  input  wire logic                             end_of_program_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  kind_o,
  output logic signed [rbe_pkg::DataW-1:0]      value_o
);
  import rbe_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StDiv
  } state_e;

  state_e           state_q, state_d;
  logic             halted_q, halted_d;
  op_e              op_q, op_d;
  logic [IdxW-1:0]  dest_q, dest_d;
  logic [DataW-1:0] k_q, k_d;
  logic             eop_q, eop_d;
  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic [DataW-1:0] value_q, value_d;

  logic             rf_re, rf_we;
  logic [IdxW-1:0]  ra_addr;
  logic [DataW-1:0] a_rd, b_rd, rf_wd, alu_res, div_quo;
  logic             div_start, out_free;
  div_status_t      div_st;

  assign in_stall_o = (state_q != StIdle);
  assign rf_re      = in_valid_i && (state_q == StIdle) && !halted_q;
  assign ra_addr    = (op_e'(operation_i) == OpPrint) ? dest_index_i : left_index_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  rbe_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk_i,
    .rst_ni,
    .re_i      (rf_re),
    .ra_addr_i (ra_addr),
    .rb_addr_i (right_index_i),
    .ra_data_o (a_rd),
    .rb_data_o (b_rd),
    .we_i      (rf_we),
    .wa_i      (dest_q),
    .wd_i      (rf_wd)
  );

  rbe_divider u_divider (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (a_rd),
    .divisor_i  (b_rd),
    .status_o   (div_st),
    .quotient_o (div_quo)
  );

  always_comb begin
    unique case (op_q)
      OpAdd:   alu_res = a_rd + b_rd;
      OpSub:   alu_res = a_rd - b_rd;
      OpMul:   alu_res = a_rd * b_rd;
      default: alu_res = k_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    halted_d    = halted_q;
    op_d        = op_q;
    dest_d      = dest_q;
    k_d         = k_q;
    eop_d       = eop_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    value_d     = value_q;
    rf_we       = 1'b0;
    rf_wd       = alu_res;
    div_start   = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d   = op_e'(operation_i);
          dest_d = dest_index_i;
          k_d    = constant_i;
          eop_d  = end_of_program_i;
          if (halted_q) begin
            if (end_of_program_i) begin
              halted_d = 1'b0;
            end
          end else begin
            state_d = StExec;
          end
        end
      end
      StExec: begin
        state_d = StIdle;
        unique case (op_q)
          OpLoadk, OpAdd, OpSub, OpMul: begin
            rf_we = 1'b1;
          end
          OpDiv: begin
            if (b_rd == '0) begin
              if (out_free) begin
                out_valid_d = 1'b1;
                kind_d      = KindDivZero;
                value_d     = '0;
              end else begin
                state_d = StExec;
              end
            end else begin
              div_start = 1'b1;
              state_d   = StDiv;
            end
          end
          OpPrint: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              kind_d      = KindValue;
              value_d     = a_rd;
            end else begin
              state_d = StExec;
            end
          end
          OpHalt: begin
            halted_d = !eop_q;
          end
          OpNop: begin
          end
        endcase
      end
      StDiv: begin
        if (div_st.done) begin
          rf_we   = 1'b1;
          rf_wd   = div_quo;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      halted_q    <= 1'b0;
      op_q        <= OpNop;
      dest_q      <= '0;
      k_q         <= '0;
      eop_q       <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KindValue;
      value_q     <= '0;
    end else begin
      state_q     <= state_d;
      halted_q    <= halted_d;
      op_q        <= op_d;
      dest_q      <= dest_d;
      k_q         <= k_d;
      eop_q       <= eop_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      value_q     <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;

  `RBE_ASSERT(a_div_busy_in_div, div_st.busy |-> state_q == StDiv, "divider busy outside divide")
  `RBE_ASSERT(a_div_done_in_div, div_st.done |-> state_q == StDiv, "divider done outside divide")
  `RBE_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(state_q) == StExec, "result not from execute")
  `RBE_ASSERT_NEXT(a_halt_drops, halted_q && in_valid_i && state_q == StIdle, state_q == StIdle, "word executed while halted")

endmodule

`default_nettype wire
